// ===== hdl/qrpid_pkg.sv =====
// ----------------------------------------------------------------------------
// qrpid_pkg
// Shared constants, register indexes and helpers for the quad rate pid mixer.
// ----------------------------------------------------------------------------
package qrpid_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 10;

   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 10;
   localparam int RATE_W  = 16;
   localparam int ERR_W   = 17;
   localparam int THR_W   = 11;
   localparam int MOTOR_W = 11;
   localparam int CSR_W   = 48;
   localparam int CSR_IDX_W = 3;
   localparam int AXES    = 3;
   localparam int AXIS_W  = LIMIT_W + 1;  // clamped axis output, signed
   localparam int MIX_W   = 14;           // throttle plus three axis terms, signed

   localparam logic [THR_W-1:0]   THR_CAP   = 11'd1800;
   localparam logic [MOTOR_W-1:0] MOTOR_MIN = 11'd1100;
   localparam logic [MOTOR_W-1:0] MOTOR_MAX = 11'd2000;
   localparam logic [MOTOR_W-1:0] MOTOR_OFF = 11'd1000;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd400;

   localparam logic [CSR_IDX_W-1:0] REG_ROLL_GAINS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_GAINS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_GAINS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_LIMIT   = 3'd5;

   localparam int AX_ROLL  = 0;
   localparam int AX_PITCH = 1;
   localparam int AX_YAW   = 2;

   function automatic logic [MOTOR_W-1:0] motor_clip(input logic signed [MIX_W-1:0] v);
      logic [MOTOR_W-1:0] res;
      if (v > $signed({3'b000, MOTOR_MAX})) begin
         res = MOTOR_MAX;
      end else if (v < $signed({3'b000, MOTOR_MIN})) begin
         res = MOTOR_MIN;
      end else begin
         res = v[MOTOR_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hdl/quad_rate_pid_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// quad_rate_pid_motor_mixer
// Three-axis rate pid with x-frame mixing into four motor pulses.
// ----------------------------------------------------------------------------
// One control tick is accepted per clock cycle while the input register is
// free or can pass its tick on. A tick lands in an input register and moves
// into the result register once that register is free; rsp_valid then rises
// and the word is held there until rsp_ready takes it. The sustained rate
// of one tick per cycle, when the output is not stalled, is set by the
// integrator and previous-error feedback, which closes through the single
// pass of pid and mixing logic between the input and result registers.
// Gains are unsigned 16-bit words with GAIN_FRAC_BITS fraction bits, Q6.10
// at the default, and limits apply to both the integrator and the axis
// output. Disarmed ticks give 1000 on every motor and clear the integrators.
// Configuration should be written while no tick is in flight.
module quad_rate_pid_motor_mixer #(
   parameter int GAIN_FRAC_BITS = qrpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [qrpid_pkg::RATE_W-1:0]    req_roll_rate,
   input  logic signed [qrpid_pkg::RATE_W-1:0]    req_pitch_rate,
   input  logic signed [qrpid_pkg::RATE_W-1:0]    req_yaw_rate,
   input  logic signed [qrpid_pkg::RATE_W-1:0]    req_roll_target,
   input  logic signed [qrpid_pkg::RATE_W-1:0]    req_pitch_target,
   input  logic signed [qrpid_pkg::RATE_W-1:0]    req_yaw_target,
   input  logic        [qrpid_pkg::THR_W-1:0]     req_throttle,
   input  logic                                   req_armed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [qrpid_pkg::MOTOR_W-1:0]   rsp_motor_front_left,
   output logic        [qrpid_pkg::MOTOR_W-1:0]   rsp_motor_front_right,
   output logic        [qrpid_pkg::MOTOR_W-1:0]   rsp_motor_rear_right,
   output logic        [qrpid_pkg::MOTOR_W-1:0]   rsp_motor_rear_left,
   input  logic                                   csr_write_enable,
   input  logic        [qrpid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [qrpid_pkg::CSR_W-1:0]     csr_data
);

   localparam int F      = GAIN_FRAC_BITS;
   localparam int INT_W  = qrpid_pkg::LIMIT_W + F + 1;       // holds +/- limit << F
   localparam int PROD_W = 35;                                // 16u x 18s product
   localparam int SUM_W  = PROD_W + 3;
   localparam int SHR_W  = SUM_W - F;
   localparam int RW     = qrpid_pkg::RATE_W;
   localparam int EW     = qrpid_pkg::ERR_W;
   localparam int GW     = qrpid_pkg::GAIN_W;
   localparam int LW     = qrpid_pkg::LIMIT_W;
   localparam int AW     = qrpid_pkg::AXIS_W;
   localparam int MW     = qrpid_pkg::MIX_W;

   // configuration
   logic [qrpid_pkg::CSR_W-1:0] gains_ff [qrpid_pkg::AXES];
   logic [LW-1:0]               limit_ff [qrpid_pkg::AXES];

   // pid state
   logic signed [INT_W-1:0] integ_ff  [qrpid_pkg::AXES];
   logic signed [INT_W-1:0] integ_in  [qrpid_pkg::AXES];
   logic signed [EW-1:0]    prev_ff   [qrpid_pkg::AXES];
   logic signed [EW-1:0]    prev_in   [qrpid_pkg::AXES];

   // input register
   logic                           in_valid_ff;
   logic signed [RW-1:0]           rate_ff   [qrpid_pkg::AXES];
   logic signed [RW-1:0]           target_ff [qrpid_pkg::AXES];
   logic [qrpid_pkg::THR_W-1:0]    throttle_ff;
   logic                           armed_ff;

   // result register
   logic                           out_valid_ff;
   logic [qrpid_pkg::MOTOR_W-1:0]  motor_fl_ff, motor_fr_ff, motor_rr_ff, motor_rl_ff;
   logic [qrpid_pkg::MOTOR_W-1:0]  motor_fl_in, motor_fr_in, motor_rr_in, motor_rl_in;

   logic out_free;
   logic advance;
   logic req_take;

   logic signed [AW-1:0] axis_out [qrpid_pkg::AXES];

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // per-axis pid, one pass
   always_comb begin
      logic signed [EW-1:0]      e;
      logic signed [PROD_W-1:0]  e_x, de_x, kp_x, ki_x, kd_x;
      logic signed [PROD_W-1:0]  p_prod, i_prod, d_prod;
      logic signed [PROD_W-1:0]  i_sum, lim_f;
      logic signed [INT_W-1:0]   i_clip;
      logic signed [SUM_W-1:0]   sum;
      logic signed [SHR_W-1:0]   sh, lim_x;
      for (int a = 0; a < qrpid_pkg::AXES; a++) begin
         e      = EW'(rate_ff[a]) - EW'(target_ff[a]);
         e_x    = PROD_W'(e);
         de_x   = PROD_W'(e) - PROD_W'(prev_ff[a]);
         kp_x   = $signed(PROD_W'(gains_ff[a][GW-1:0]));
         ki_x   = $signed(PROD_W'(gains_ff[a][2*GW-1:GW]));
         kd_x   = $signed(PROD_W'(gains_ff[a][3*GW-1:2*GW]));
         p_prod = kp_x * e_x;
         i_prod = ki_x * e_x;
         d_prod = kd_x * de_x;
         lim_f  = PROD_W'($signed({1'b0, limit_ff[a], {F{1'b0}}}));
         i_sum  = PROD_W'(integ_ff[a]) + i_prod;
         if (i_sum > lim_f) begin
            i_clip = INT_W'(lim_f);
         end else if (i_sum < -lim_f) begin
            i_clip = INT_W'(-lim_f);
         end else begin
            i_clip = INT_W'(i_sum);
         end
         sum    = SUM_W'(p_prod) + SUM_W'(i_clip) + SUM_W'(d_prod);
         // floor shift drops the fraction bits
         sh     = sum[SUM_W-1:F];
         lim_x  = SHR_W'($signed({1'b0, limit_ff[a]}));
         if (sh > lim_x) begin
            axis_out[a] = AW'(lim_x);
         end else if (sh < -lim_x) begin
            axis_out[a] = AW'(-lim_x);
         end else begin
            axis_out[a] = AW'(sh);
         end
         if (armed_ff) begin
            integ_in[a] = i_clip;
            prev_in[a]  = e;
         end else begin
            integ_in[a] = '0;
            prev_in[a]  = prev_ff[a];
         end
      end
   end

   // x mixing
   always_comb begin
      logic signed [MW-1:0] thr, r, p, y;
      logic [qrpid_pkg::THR_W-1:0] thr_cap;
      thr_cap = (throttle_ff > qrpid_pkg::THR_CAP) ? qrpid_pkg::THR_CAP : throttle_ff;
      thr = $signed(MW'(thr_cap));
      r   = MW'(axis_out[qrpid_pkg::AX_ROLL]);
      p   = MW'(axis_out[qrpid_pkg::AX_PITCH]);
      y   = MW'(axis_out[qrpid_pkg::AX_YAW]);
      if (armed_ff) begin
         motor_fl_in = qrpid_pkg::motor_clip(thr + p - r - y);
         motor_fr_in = qrpid_pkg::motor_clip(thr + p + r + y);
         motor_rr_in = qrpid_pkg::motor_clip(thr - p + r - y);
         motor_rl_in = qrpid_pkg::motor_clip(thr - p - r + y);
      end else begin
         motor_fl_in = qrpid_pkg::MOTOR_OFF;
         motor_fr_in = qrpid_pkg::MOTOR_OFF;
         motor_rr_in = qrpid_pkg::MOTOR_OFF;
         motor_rl_in = qrpid_pkg::MOTOR_OFF;
      end
   end

   // control, configuration and pid state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int a = 0; a < qrpid_pkg::AXES; a++) begin
            gains_ff[a] <= '0;
            limit_ff[a] <= qrpid_pkg::LIMIT_RESET;
            integ_ff[a] <= '0;
            prev_ff[a]  <= '0;
         end
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            for (int a = 0; a < qrpid_pkg::AXES; a++) begin
               integ_ff[a] <= integ_in[a];
               prev_ff[a]  <= prev_in[a];
            end
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               qrpid_pkg::REG_ROLL_GAINS: begin
                  gains_ff[qrpid_pkg::AX_ROLL] <= csr_data;
               end
               qrpid_pkg::REG_PITCH_GAINS: begin
                  gains_ff[qrpid_pkg::AX_PITCH] <= csr_data;
               end
               qrpid_pkg::REG_YAW_GAINS: begin
                  gains_ff[qrpid_pkg::AX_YAW] <= csr_data;
               end
               qrpid_pkg::REG_ROLL_LIMIT: begin
                  limit_ff[qrpid_pkg::AX_ROLL] <= csr_data[LW-1:0];
               end
               qrpid_pkg::REG_PITCH_LIMIT: begin
                  limit_ff[qrpid_pkg::AX_PITCH] <= csr_data[LW-1:0];
               end
               qrpid_pkg::REG_YAW_LIMIT: begin
                  limit_ff[qrpid_pkg::AX_YAW] <= csr_data[LW-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         rate_ff[qrpid_pkg::AX_ROLL]    <= req_roll_rate;
         rate_ff[qrpid_pkg::AX_PITCH]   <= req_pitch_rate;
         rate_ff[qrpid_pkg::AX_YAW]     <= req_yaw_rate;
         target_ff[qrpid_pkg::AX_ROLL]  <= req_roll_target;
         target_ff[qrpid_pkg::AX_PITCH] <= req_pitch_target;
         target_ff[qrpid_pkg::AX_YAW]   <= req_yaw_target;
         throttle_ff                    <= req_throttle;
         armed_ff                       <= req_armed;
      end
      if (advance) begin
         motor_fl_ff <= motor_fl_in;
         motor_fr_ff <= motor_fr_in;
         motor_rr_ff <= motor_rr_in;
         motor_rl_ff <= motor_rl_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_motor_front_left  = motor_fl_ff;
   assign rsp_motor_front_right = motor_fr_ff;
   assign rsp_motor_rear_right  = motor_rr_ff;
   assign rsp_motor_rear_left   = motor_rl_ff;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quad rate pid motor mixer. Control ticks are
// offered on the request channel with random gaps, motor words are drained
// with random stalls and one long hold-off, and every accepted word is checked
// against the table on the first pass, else an in-bench pid and mixer predictor.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD       = 10;
   localparam int FRAC             = qrpid_pkg::GAIN_FRAC_BITS_DEF;
   localparam int LATENCY          = 2;
   localparam int DIR_ROWS         = 12;
   localparam int RANDOM_PHASES    = 6;
   localparam int TICKS_PER_PHASE  = 175;
   localparam int HOLD_AT_TICK     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_REPORTS      = 10;
   localparam int TIMEOUT_NS       = 5_000_000;

   localparam int AXES   = qrpid_pkg::AXES;
   localparam int RW     = qrpid_pkg::RATE_W;
   localparam int TW     = qrpid_pkg::THR_W;
   localparam int MW     = qrpid_pkg::MOTOR_W;
   localparam int CW     = qrpid_pkg::CSR_W;
   localparam int IW     = qrpid_pkg::CSR_IDX_W;
   localparam int LW     = qrpid_pkg::LIMIT_W;

   localparam int AX_R   = qrpid_pkg::AX_ROLL;
   localparam int AX_P   = qrpid_pkg::AX_PITCH;
   localparam int AX_Y   = qrpid_pkg::AX_YAW;

   localparam logic [MW-1:0] M_CAP = qrpid_pkg::THR_CAP;
   localparam logic [MW-1:0] M_MIN = qrpid_pkg::MOTOR_MIN;
   localparam logic [MW-1:0] M_MAX = qrpid_pkg::MOTOR_MAX;
   localparam logic [MW-1:0] M_OFF = qrpid_pkg::MOTOR_OFF;

   // indexes past the last register, writes there must be dropped
   localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

   localparam logic signed [RW-1:0] RATE_MAX = 16'sh7fff;
   localparam logic signed [RW-1:0] RATE_MIN = 16'sh8000;

   typedef enum int {GAINS_TUNED, GAINS_FULL_SCALE, GAINS_RAW} gain_style_type;

   typedef struct packed {
      logic signed [RW-1:0] roll_rate;
      logic signed [RW-1:0] pitch_rate;
      logic signed [RW-1:0] yaw_rate;
      logic signed [RW-1:0] roll_target;
      logic signed [RW-1:0] pitch_target;
      logic signed [RW-1:0] yaw_target;
      logic [TW-1:0]        throttle;
      logic                 armed;
   } tick_type;

   // index 0 front left, 1 front right, 2 rear right, 3 rear left
   typedef logic [3:0][MW-1:0] motor_word_type;

   typedef struct {
      tick_type      tick;
      logic [MW-1:0] zero_gain_motor;  // every motor, with reset settings
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [RW-1:0] req_roll_rate = '0;
   logic signed [RW-1:0] req_pitch_rate = '0;
   logic signed [RW-1:0] req_yaw_rate = '0;
   logic signed [RW-1:0] req_roll_target = '0;
   logic signed [RW-1:0] req_pitch_target = '0;
   logic signed [RW-1:0] req_yaw_target = '0;
   logic [TW-1:0]        req_throttle = '0;
   logic                 req_armed = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [MW-1:0]        rsp_motor_front_left;
   logic [MW-1:0]        rsp_motor_front_right;
   logic [MW-1:0]        rsp_motor_rear_right;
   logic [MW-1:0]        rsp_motor_rear_left;
   logic                 csr_write_enable = 1'b0;
   logic [IW-1:0]        csr_index = '0;
   logic [CW-1:0]        csr_data = '0;

   // predictor copy of settings and loop state
   logic [CW-1:0] axis_gains [AXES] = '{default: '0};
   logic [LW-1:0] axis_limit [AXES] = '{default: qrpid_pkg::LIMIT_RESET};
   longint        integ_acc  [AXES] = '{default: 0};
   longint        last_err   [AXES] = '{default: 0};

   motor_word_type pending_motors [$];

   int  ticks_accepted = 0;
   int  disarmed_ticks = 0;
   int  results_checked = 0;
   int  fault_count = 0;
   int  settings_loaded = 0;
   int  sender_calm_left = 0;
   bit  long_hold_done = 1'b0;

   string motor_name [4] = '{"front_left", "front_right", "rear_right", "rear_left"};

   dir_row_type dir_table [DIR_ROWS] = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 11'd1500, 1'b1}, 11'd1500},
      '{'{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MIN, RATE_MIN, RATE_MIN, 11'd1800, 1'b1}, M_CAP},
      '{'{RATE_MIN, RATE_MIN, RATE_MIN, RATE_MAX, RATE_MAX, RATE_MAX, 11'd2047, 1'b1}, M_CAP},
      '{'{RATE_MAX, RATE_MIN, RATE_MAX, RATE_MIN, RATE_MAX, RATE_MIN, 11'd1801, 1'b1}, M_CAP},
      '{'{16'sd100, -16'sd200, 16'sd300, 16'sd0, 16'sd0, 16'sd0, 11'd0, 1'b1}, M_MIN},
      '{'{-16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 11'd1099, 1'b1}, M_MIN},
      '{'{16'sd5, 16'sd6, 16'sd7, -16'sd5, -16'sd6, -16'sd7, 11'd1100, 1'b1}, M_MIN},
      '{'{RATE_MAX, RATE_MAX, RATE_MAX, 16'sd0, 16'sd0, 16'sd0, 11'd1500, 1'b0}, M_OFF},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 11'd2047, 1'b0}, M_OFF},
      '{'{16'sd250, -16'sd250, 16'sd125, -16'sd125, 16'sd40, -16'sd40, 11'd1234, 1'b1},
        11'd1234},
      '{'{RATE_MIN, RATE_MIN, RATE_MIN, 16'sd0, 16'sd0, 16'sd0, 11'd2000, 1'b1}, M_CAP},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 11'd0, 1'b0}, M_OFF}
   };

   quad_rate_pid_motor_mixer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_roll_rate         (req_roll_rate),
      .req_pitch_rate        (req_pitch_rate),
      .req_yaw_rate          (req_yaw_rate),
      .req_roll_target       (req_roll_target),
      .req_pitch_target      (req_pitch_target),
      .req_yaw_target        (req_yaw_target),
      .req_throttle          (req_throttle),
      .req_armed             (req_armed),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_motor_front_left  (rsp_motor_front_left),
      .rsp_motor_front_right (rsp_motor_front_right),
      .rsp_motor_rear_right  (rsp_motor_rear_right),
      .rsp_motor_rear_left   (rsp_motor_rear_left),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void report_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   // one pid axis: integrator and output share the same symmetric limit
   function automatic longint axis_step(input int a, input longint err);
      longint kp, ki, kd, lim, lim_fx, sum;
      kp = longint'(axis_gains[a][15:0]);
      ki = longint'(axis_gains[a][31:16]);
      kd = longint'(axis_gains[a][47:32]);
      lim = longint'(axis_limit[a]);
      lim_fx = lim <<< FRAC;
      integ_acc[a] = clip(integ_acc[a] + ki * err, -lim_fx, lim_fx);
      sum = kp * err + integ_acc[a] + kd * (err - last_err[a]);
      last_err[a] = err;
      // arithmetic shift floors toward minus infinity
      return clip(sum >>> FRAC, -lim, lim);
   endfunction

   function automatic logic [MW-1:0] motor_pulse(input longint v);
      return MW'(clip(v, longint'(M_MIN), longint'(M_MAX)));
   endfunction

   function automatic motor_word_type predict_motors(input tick_type t);
      longint out_r, out_p, out_y, thr;
      motor_word_type m;
      int a;
      if (!t.armed) begin
         // disarmed clears integrators but keeps the last errors
         for (a = 0; a < AXES; a++) integ_acc[a] = 0;
         return {4{M_OFF}};
      end
      out_r = axis_step(AX_R,
                        longint'($signed(t.roll_rate)) - longint'($signed(t.roll_target)));
      out_p = axis_step(AX_P,
                        longint'($signed(t.pitch_rate)) - longint'($signed(t.pitch_target)));
      out_y = axis_step(AX_Y,
                        longint'($signed(t.yaw_rate)) - longint'($signed(t.yaw_target)));
      thr = longint'(t.throttle);
      if (thr > longint'(M_CAP)) thr = longint'(M_CAP);
      m[0] = motor_pulse(thr + out_p - out_r - out_y);
      m[1] = motor_pulse(thr + out_p + out_r + out_y);
      m[2] = motor_pulse(thr - out_p + out_r - out_y);
      m[3] = motor_pulse(thr - out_p - out_r + out_y);
      return m;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [CW-1:0] pick_gains(input gain_style_type style);
      logic [CW-1:0] g;
      case (style)
         GAINS_TUNED: begin
            g = {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 128)),
                 16'($urandom_range(0, 4096))};
         end
         GAINS_FULL_SCALE: begin
            g = {3{16'hffff}};
         end
         default: begin
            g = {16'($urandom), 32'($urandom)};
         end
      endcase
      return g;
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      logic signed [RW-1:0] tgt [AXES];
      logic signed [RW-1:0] rate [AXES];
      int mode, delta, a;
      mode = $urandom_range(0, 9);
      for (a = 0; a < AXES; a++) begin
         // small tracking errors keep the integrators off their rails
         delta = int'($urandom_range(0, 600)) - 300;
         if (mode < 5) begin
            tgt[a] = 16'(int'($urandom_range(0, 2000)) - 1000);
            rate[a] = tgt[a] + 16'(delta);
         end else if (mode < 7) begin
            tgt[a] = 16'($urandom);
            rate[a] = tgt[a] + 16'(delta);
         end else begin
            tgt[a] = 16'($urandom);
            rate[a] = 16'($urandom);
         end
      end
      t.roll_rate = rate[AX_R];
      t.pitch_rate = rate[AX_P];
      t.yaw_rate = rate[AX_Y];
      t.roll_target = tgt[AX_R];
      t.pitch_target = tgt[AX_P];
      t.yaw_target = tgt[AX_Y];
      if ($urandom_range(0, 4) == 0) t.throttle = 11'($urandom_range(0, 2047));
      else t.throttle = 11'($urandom_range(1000, 1900));
      t.armed = ($urandom_range(0, 15) != 0);
      return t;
   endfunction

   task automatic csr_write(input logic [IW-1:0] idx, input logic [CW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         qrpid_pkg::REG_ROLL_GAINS:  axis_gains[AX_R] = data;
         qrpid_pkg::REG_PITCH_GAINS: axis_gains[AX_P] = data;
         qrpid_pkg::REG_YAW_GAINS:   axis_gains[AX_Y] = data;
         qrpid_pkg::REG_ROLL_LIMIT:  axis_limit[AX_R] = data[LW-1:0];
         qrpid_pkg::REG_PITCH_LIMIT: axis_limit[AX_P] = data[LW-1:0];
         qrpid_pkg::REG_YAW_LIMIT:   axis_limit[AX_Y] = data[LW-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [CW-1:0] gain_word [AXES],
                                 input logic [LW-1:0] lim [AXES], input bit noisy);
      logic [CW-LW-1:0] junk;
      junk = noisy ? {6'($urandom), 32'($urandom)} : '0;
      csr_write(qrpid_pkg::REG_ROLL_GAINS, gain_word[AX_R]);
      csr_write(qrpid_pkg::REG_PITCH_GAINS, gain_word[AX_P]);
      csr_write(qrpid_pkg::REG_YAW_GAINS, gain_word[AX_Y]);
      // limits only take the low bits of the data word
      csr_write(qrpid_pkg::REG_ROLL_LIMIT, {junk, lim[AX_R]});
      csr_write(qrpid_pkg::REG_PITCH_LIMIT, {junk, lim[AX_P]});
      csr_write(qrpid_pkg::REG_YAW_LIMIT, {junk, lim[AX_Y]});
      if (noisy) begin
         csr_write(REG_SPARE_LO, '1);
         csr_write(REG_SPARE_HI, '0);
      end
      csr_write_enable <= 1'b0;
      settings_loaded++;
   endtask

   task automatic load_settings(input int phase);
      logic [CW-1:0] gain_word [AXES];
      logic [LW-1:0] lim [AXES];
      int a;
      for (a = 0; a < AXES; a++) begin
         case (phase)
            1: begin
               gain_word[a] = pick_gains(GAINS_FULL_SCALE);
               lim[a] = 10'd1023;
            end
            2: begin
               gain_word[a] = pick_gains(GAINS_TUNED);
               lim[a] = '0;
            end
            3: begin
               gain_word[a] = pick_gains(GAINS_RAW);
               lim[a] = 10'($urandom_range(0, 1023));
            end
            4: begin
               gain_word[a] = (a == AX_P) ? pick_gains(GAINS_TUNED) : '0;
               lim[a] = 10'd1000;
            end
            default: begin
               gain_word[a] = pick_gains(GAINS_TUNED);
               lim[a] = 10'($urandom_range(100, 1000));
            end
         endcase
      end
      write_settings(gain_word, lim, phase == 3);
   endtask

   task automatic offer_tick(input tick_type t, input bit typed,
                             input logic [MW-1:0] typed_motor);
      int gap;
      motor_word_type predicted;
      if (sender_calm_left > 0) begin
         sender_calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 29) == 0) sender_calm_left = $urandom_range(20, 60);
         gap = gap_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_roll_rate <= t.roll_rate;
      req_pitch_rate <= t.pitch_rate;
      req_yaw_rate <= t.yaw_rate;
      req_roll_target <= t.roll_target;
      req_pitch_target <= t.pitch_target;
      req_yaw_target <= t.yaw_target;
      req_throttle <= t.throttle;
      req_armed <= t.armed;
      do @(posedge clock); while (!req_ready);
      // predictor still runs on typed rows so the loop state stays in step
      predicted = predict_motors(t);
      pending_motors.push_back(typed ? {4{typed_motor}} : predicted);
      ticks_accepted++;
      if (!t.armed) disarmed_ticks++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_motors.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CW-1:0] dir_gains [AXES];
      logic [LW-1:0] dir_limits [AXES];
      int ph, n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero gains, so armed motors follow the capped, clipped throttle
      foreach (dir_table[r]) offer_tick(dir_table[r].tick, 1'b1, dir_table[r].zero_gain_motor);
      settle();

      // same rows again with full-scale roll, zero pitch limit, widest roll limit
      dir_gains[AX_R] = pick_gains(GAINS_FULL_SCALE);
      dir_gains[AX_P] = pick_gains(GAINS_TUNED);
      dir_gains[AX_Y] = pick_gains(GAINS_RAW);
      dir_limits[AX_R] = 10'd1023;
      dir_limits[AX_P] = 10'd0;
      dir_limits[AX_Y] = 10'd1000;
      write_settings(dir_gains, dir_limits, 1'b1);
      foreach (dir_table[r]) offer_tick(dir_table[r].tick, 1'b0, '0);
      settle();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_settings(ph);
         for (n = 0; n < TICKS_PER_PHASE; n++) offer_tick(random_tick(), 1'b0, '0);
         settle();
      end

      repeat (LATENCY * 4) @(posedge clock);
      if (pending_motors.size() != 0) begin
         report_fault($sformatf("%0d motor words never arrived", pending_motors.size()));
      end
      $display("%0d ticks sent (%0d disarmed) under %0d register settings, %0d words checked",
               ticks_accepted, disarmed_ticks, settings_loaded, results_checked);
      $display("result side held off %0d cycles once while ticks kept coming", LONG_HOLD_CYCLES);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : result_sink
      int stall_left, calm_left;
      stall_left = 0;
      calm_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         // long hold-off so the block backs up into the request side
         if (!long_hold_done && ticks_accepted >= HOLD_AT_TICK) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         if (calm_left > 0) begin
            calm_left--;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(40, 200);
            else stall_left = gap_len();
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_motors
      motor_word_type want, got;
      int f;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_motor_rear_left, rsp_motor_rear_right, rsp_motor_front_right,
                rsp_motor_front_left};
         if (pending_motors.size() == 0) begin
            report_fault($sformatf("motor word %h with nothing expected", got));
         end else begin
            want = pending_motors.pop_front();
            results_checked++;
            for (f = 0; f < 4; f++) begin
               if (got[f] !== want[f]) begin
                  report_fault($sformatf("word %0d %s: expected %0d, got %0d",
                                         results_checked, motor_name[f], want[f], got[f]));
               end
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d motor words outstanding", pending_motors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== quad_rate_pid_motor_mixer.f =====
hdl/qrpid_pkg.sv
hdl/quad_rate_pid_motor_mixer.sv
tb/tb.sv
